/* sv/grid_phase_factor_generator_defines.svh */
// Assertion macros shared by the grid phase factor generator RTL.
`ifndef GRID_PHASE_FACTOR_GENERATOR_DEFINES_SVH
`define GRID_PHASE_FACTOR_GENERATOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define GPFG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpfg assertion failed");

// Expression holds at every clock edge out of reset.
`define GPFG_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("gpfg assertion failed");

`endif

/* sv/gpfg_pkg.sv */
// Shared constants, types and helper functions of the grid phase factor generator.
package gpfg_pkg;

  // Build-time sizing
  localparam int MAX_DIM       = 64;
  localparam int PHASE_BITS    = 32;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Alignment of the 32-bit steps to the phase word
  localparam int PH_UP = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
  localparam int PH_DN = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
  localparam int PH_W  = PHASE_BITS + 32;

  // Field and datapath widths
  localparam int CW     = 6;
  localparam int GDIM_W = 7;
  localparam int IDX_W  = 18;
  localparam int QW     = 16;
  localparam int DATA_W = 32;
  localparam int CIDX_W = 4;
  localparam int DIM_W  = ($clog2(MAX_DIM + 1) > GDIM_W) ? $clog2(MAX_DIM + 1) : GDIM_W;
  localparam int OFF_W  = DIM_W + 1;
  localparam int XW     = 34;
  localparam int ZW     = 33;

  localparam logic signed [XW-1:0] CORDIC_K     = XW'(652032874);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'h4000_0000);

  // Front end has four register stages, the output side two
  localparam int LATENCY = 4 + NSTG + 2;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_GRID_DIM = 4'd0,
    REG_STEP_X   = 4'd1,
    REG_STEP_Y   = 4'd2,
    REG_STEP_Z   = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GDIM_W-1:0] grid_dim;
    logic [DATA_W-1:0] step_x;
    logic [DATA_W-1:0] step_y;
    logic [DATA_W-1:0] step_z;
  } cfg_t;

  // Payload handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 flip;
    logic [IDX_W-1:0]     idx;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // Step as a PHASE_BITS fraction
  function automatic logic [PHASE_BITS-1:0] align_step(logic [DATA_W-1:0] s);
    logic [PH_W-1:0] w;
    w = (PH_W'(s) << PH_UP) >> PH_DN;
    return w[PHASE_BITS-1:0];
  endfunction

  // Top 32 bits of the phase word as the CORDIC angle
  function automatic logic [31:0] phase_top32(logic [PHASE_BITS-1:0] p);
    logic [PH_W-1:0] w;
    w = (PH_W'(p) >> PH_UP) << PH_DN;
    return w[31:0];
  endfunction

  function automatic logic signed [ZW-1:0] atan_val(logic [ATAN_IDX_W-1:0] i);
    return $signed(ZW'(ATAN_TABLE[i]));
  endfunction

endpackage

/* sv/gpfg_front.sv */
// Front end: axis offsets, phase products and sum, quadrant fold, flat index.
module gpfg_front import gpfg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_i,
  input  logic [CW-1:0] coord_x_i,
  input  logic [CW-1:0] coord_y_i,
  input  logic [CW-1:0] coord_z_i,
  input  cfg_t          cfg_i,
  output cordic_t       out_o
);

  // Offset times step, modulo one turn
  function automatic logic [PHASE_BITS-1:0] phase_mul(logic signed [OFF_W-1:0] o,
                                                      logic [PHASE_BITS-1:0] s);
    logic signed [OFF_W+PHASE_BITS:0] m;
    m = o * $signed({1'b0, s});
    return m[PHASE_BITS-1:0];
  endfunction

  logic [DIM_W-1:0] dim_raw, dim_c, half;

  logic                    v1_q, v2_q, v3_q;
  logic signed [OFF_W-1:0] offx_q, offy_q, offz_q;
  logic [IDX_W-1:0]        idx1_q, idx2_q, idx3_q;
  logic [CW-1:0]           cz1_q;
  logic [PHASE_BITS-1:0]   px_q, py_q, pz_q, phase_q;
  cordic_t                 out_q, out_d;

  logic [31:0] ang;
  logic        flip;

  // Edge length clamp and half edge
  always_comb begin
    dim_raw = DIM_W'(cfg_i.grid_dim);
    if (dim_raw == '0) begin
      dim_c = DIM_W'(1);
    end else if (dim_raw > DIM_W'(MAX_DIM)) begin
      dim_c = DIM_W'(MAX_DIM);
    end else begin
      dim_c = dim_raw;
    end
    half = dim_c >> 1;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: offsets and partial index
  always_ff @(posedge clk_i) begin
    offx_q <= $signed({1'b0, DIM_W'(coord_x_i)}) - $signed({1'b0, half});
    offy_q <= $signed({1'b0, DIM_W'(coord_y_i)}) - $signed({1'b0, half});
    offz_q <= $signed({1'b0, DIM_W'(coord_z_i)}) - $signed({1'b0, half});
    idx1_q <= IDX_W'(coord_x_i) * IDX_W'(dim_c) + IDX_W'(coord_y_i);
    cz1_q  <= coord_z_i;
  end

  // Stage 2: per-axis phase products, full index
  always_ff @(posedge clk_i) begin
    px_q   <= phase_mul(offx_q, align_step(cfg_i.step_x));
    py_q   <= phase_mul(offy_q, align_step(cfg_i.step_y));
    pz_q   <= phase_mul(offz_q, align_step(cfg_i.step_z));
    idx2_q <= idx1_q * IDX_W'(dim_c) + IDX_W'(cz1_q);
  end

  // Stage 3: phase sum wraps modulo one turn
  always_ff @(posedge clk_i) begin
    phase_q <= px_q + py_q + pz_q;
    idx3_q  <= idx2_q;
  end

  // Stage 4: fold into [-1/4, 1/4] turn
  always_comb begin
    ang  = phase_top32(phase_q);
    flip = (!ang[31] && (ang[30:0] > 31'h4000_0000)) ||
           (ang[31] && (ang[30:0] < 31'h4000_0000));
    out_d.valid = v3_q;
    out_d.flip  = flip;
    out_d.idx   = idx3_q;
    out_d.x     = CORDIC_K;
    out_d.y     = '0;
    out_d.z     = flip ? ZW'($signed({~ang[31], ang[30:0]})) : ZW'($signed(ang));
  end

  // Hand-off register to the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

/* sv/gpfg_cell.sv */
// One CORDIC rotation cell: a micro-rotation by atan(2^-stage), then hand-off.
module gpfg_cell import gpfg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ATAN_IDX_W-1:0] stage_i,
  input  cordic_t               in_i,
  output cordic_t               out_o
);

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  cordic_t              out_d, out_q;

  // Rotate toward zero residual angle
  always_comb begin
    dx    = in_i.y >>> stage_i;
    dy    = in_i.x >>> stage_i;
    da    = atan_val(stage_i);
    out_d = in_i;
    if (!in_i.z[ZW-1]) begin
      out_d.x = in_i.x - dx;
      out_d.y = in_i.y + dy;
      out_d.z = in_i.z - da;
    end else begin
      out_d.x = in_i.x + dx;
      out_d.y = in_i.y - dy;
      out_d.z = in_i.z + da;
    end
  end

  // Hand-off register to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

/* sv/gpfg_back.sv */
// Output side: quadrant unfold, sine negation, Q4.30 to Q1.15 rounding and saturation.
module gpfg_back import gpfg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cordic_t               in_i,
  output logic                  valid_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic signed [QW-1:0]  re_o,
  output logic signed [QW-1:0]  im_o
);

  localparam int RW = XW - 14;
  localparam logic signed [RW-1:0] QMAX = RW'(32767);
  localparam logic signed [RW-1:0] QMIN = -RW'(32768);

  // Round half up, then clamp to 16 bits
  function automatic logic signed [QW-1:0] to_q15(logic signed [XW-1:0] v);
    logic signed [XW:0]   r;
    logic signed [RW-1:0] s;
    r = (XW+1)'(v) + (XW+1)'(1 << 14);
    s = r[XW:15];
    if (s > QMAX) begin
      return QW'(QMAX);
    end else if (s < QMIN) begin
      return QW'(QMIN);
    end
    return s[QW-1:0];
  endfunction

  logic                 v1_q, v2_q;
  logic [IDX_W-1:0]     idx1_q, idx2_q;
  logic signed [XW-1:0] xs_q, ys_q;
  logic signed [QW-1:0] re_q, im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
    end
  end

  // Unfold the half turn; imaginary part is the negated sine
  always_ff @(posedge clk_i) begin
    xs_q   <= in_i.flip ? -in_i.x : in_i.x;
    ys_q   <= in_i.flip ? in_i.y : -in_i.y;
    idx1_q <= in_i.idx;
  end

  always_ff @(posedge clk_i) begin
    re_q   <= to_q15(xs_q);
    im_q   <= to_q15(ys_q);
    idx2_q <= idx1_q;
  end

  assign valid_o = v2_q;
  assign idx_o   = idx2_q;
  assign re_o    = re_q;
  assign im_o    = im_q;

endmodule

/* sv/grid_phase_factor_generator.sv */
// Grid phase factor generator top level: config registers, front end, CORDIC cell row, output.
// One grid point is taken per clock whenever start is high (busy stays low), and its
// result appears on the result ports, marked by result_valid_o, after passing through
// four front-end stages (offsets, phase products, phase sum, quadrant fold), one register
// per CORDIC cell, and two output stages.
// Results come in request order and there is no output buffering: the receiver must take
// each result in the cycle it is shown. Configuration writes are always ready and must be
// made only while no request is in flight.
module grid_phase_factor_generator import gpfg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CW-1:0]        coord_x_i,
  input  logic [CW-1:0]        coord_y_i,
  input  logic [CW-1:0]        coord_z_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CIDX_W-1:0]    cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     flat_index_o,
  output logic signed [QW-1:0] real_part_o,
  output logic signed [QW-1:0] imag_part_o
);

`include "grid_phase_factor_generator_defines.svh"

  logic    req;
  cfg_t    cfg_q;
  cordic_t chain [NSTG+1];

  // Fully pipelined: never busy
  assign busy        = 1'b0;
  assign req         = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_dim <= GDIM_W'(1);
      cfg_q.step_x   <= '0;
      cfg_q.step_y   <= '0;
      cfg_q.step_z   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_DIM: cfg_q.grid_dim <= cfg_data_i[GDIM_W-1:0];
        REG_STEP_X:   cfg_q.step_x   <= cfg_data_i;
        REG_STEP_Y:   cfg_q.step_y   <= cfg_data_i;
        REG_STEP_Z:   cfg_q.step_z   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  gpfg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .cfg_i     (cfg_q),
    .out_o     (chain[0])
  );

  // Row of CORDIC cells
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    gpfg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (ATAN_IDX_W'(g)),
      .in_i    (chain[g]),
      .out_o   (chain[g+1])
    );
  end

  gpfg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (chain[NSTG]),
    .valid_o (result_valid_o),
    .idx_o   (flat_index_o),
    .re_o    (real_part_o),
    .im_o    (imag_part_o)
  );

  // Fixed latency from request to result
  `GPFG_ASSERT_IMP(a_latency, result_valid_o, $past(req, LATENCY))
  // Folded angle must stay within a quarter turn
  `GPFG_ASSERT_IMP(a_fold_range, chain[0].valid, (chain[0].z <= QUARTER_TURN) && (chain[0].z >= -QUARTER_TURN))
  // Unit vector: both parts cannot sit at full negative scale
  `GPFG_ASSERT_IMP(a_unit_mag, result_valid_o, (real_part_o != -16'sd32768) || (imag_part_o != -16'sd32768))

endmodule
